// ===== rtl/multiply_divide_register_unit_defines.svh =====
// assertion macros for the multiply/divide register unit checker
// needs clk and rst_n in the scope of use
`ifndef MULTIPLY_DIVIDE_REGISTER_UNIT_DEFINES_SVH
`define MULTIPLY_DIVIDE_REGISTER_UNIT_DEFINES_SVH

// checked only out of reset
`define MDRU_ASSERT(lbl, pe, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pe) else $error(msg);

// checked on every edge, reset included
`define MDRU_ASSERT_ALWAYS(lbl, pe, msg) \
  lbl: assert property (@(posedge clk) pe) else $error(msg);

`endif

// ===== rtl/mdru_pkg.sv =====
// types and constants of the multiply/divide register unit
// used by every file of the block but the assertion macro header; depends on nothing
package mdru_pkg;

  localparam int BYTE_W       = 8;
  localparam int WORD_W       = 16;
  localparam int ADDR_W       = 3;
  localparam int NUM_OPERANDS = 6;

  localparam int MUL_STEPS = 8;
  localparam int DIV_STEPS = 16;
  localparam int MUL_CNT_W = 3;
  localparam int DIV_CNT_W = 4;
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_STEPS - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // access kind
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // write addresses
  localparam logic [ADDR_W-1:0] ADDR_MUL_A   = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_MUL_B   = 3'd1;
  localparam logic [ADDR_W-1:0] ADDR_DIVR_HI = 3'd2;
  localparam logic [ADDR_W-1:0] ADDR_DIVR_LO = 3'd3;
  localparam logic [ADDR_W-1:0] ADDR_DIVD_HI = 3'd4;
  localparam logic [ADDR_W-1:0] ADDR_DIVD_LO = 3'd5;

  // read addresses
  localparam logic [ADDR_W-1:0] ADDR_PROD_LO = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_PROD_HI = 3'd1;
  localparam logic [ADDR_W-1:0] ADDR_REM_LO  = 3'd2;
  localparam logic [ADDR_W-1:0] ADDR_REM_HI  = 3'd3;
  localparam logic [ADDR_W-1:0] ADDR_QUOT_LO = 3'd4;
  localparam logic [ADDR_W-1:0] ADDR_QUOT_HI = 3'd5;

  localparam logic [WORD_W-1:0] ZDIV_QUOT = 16'hffff;
  localparam logic [WORD_W-1:0] ZDIV_REM  = 16'h0000;
  localparam logic [BYTE_W-1:0] WRITE_RD  = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } mdru_state_t;

  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] mcand;
    logic [BYTE_W-1:0] mplier;
  } mdru_mul_req_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } mdru_div_req_t;

endpackage

// ===== rtl/mdru_if.sv =====
// valid/ready channels of the multiply/divide register unit
// depends on mdru_pkg for the field widths
interface mdru_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [mdru_pkg::ADDR_W-1:0]         reg_offset;
  logic [mdru_pkg::BYTE_W-1:0]         write_data;

  modport source (output valid, func, reg_offset, write_data, input ready);
  modport sink   (input valid, func, reg_offset, write_data, output ready);
endinterface

interface mdru_out_if;
  logic                        valid;
  logic                        ready;
  logic [mdru_pkg::BYTE_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

// ===== rtl/multiply_divide_register_unit.sv =====
// multiply/divide register unit: one bus access per word, read data registered,
// so every word gives its result in the cycle after it is taken
// reads and plain writes: one word a cycle while the output is not held; a write to
// address 1 runs the serial multiplier and a write to address 5 runs the divider,
// and no word is taken while either runs, one bit per cycle in each unit
// synchronous active-low reset clears operand bytes, product, quotient, remainder
module multiply_divide_register_unit (
  input  logic        clk,
  input  logic        rst_n,
  mdru_in_if.sink     in_bus,
  mdru_out_if.source  out_bus
);

  mdru_pkg::mdru_state_t                state_r, state_nxt;
  logic [mdru_pkg::BYTE_W-1:0]          opnd_r [mdru_pkg::NUM_OPERANDS];
  logic                                 out_valid_r, out_valid_nxt;
  logic [mdru_pkg::BYTE_W-1:0]          out_data_r, out_data_nxt;

  mdru_pkg::mdru_mul_req_t              mul_req;
  mdru_pkg::mdru_div_req_t              div_req;
  logic                                 mul_start, div_start;
  logic                                 mul_done, div_done;
  logic [mdru_pkg::WORD_W-1:0]          product, quotient, remainder;

  logic                                 in_acc;
  logic                                 is_write;
  logic [mdru_pkg::BYTE_W-1:0]          rd_byte;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign is_write = (in_bus.func == mdru_pkg::FUNC_WRITE);

  // operands of each operation take the byte its own write carries
  assign mul_req.start    = mul_start;
  assign mul_req.mcand    = opnd_r[mdru_pkg::ADDR_MUL_A];
  assign mul_req.mplier   = in_bus.write_data;
  assign div_req.start    = div_start;
  assign div_req.divisor  = {opnd_r[mdru_pkg::ADDR_DIVR_HI], opnd_r[mdru_pkg::ADDR_DIVR_LO]};
  assign div_req.dividend = {opnd_r[mdru_pkg::ADDR_DIVD_HI], in_bus.write_data};

  mdru_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .done    (mul_done),
    .product (product)
  );

  mdru_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mdru_pkg::ST_IDLE: begin
        if (in_acc && is_write && (in_bus.reg_offset == mdru_pkg::ADDR_MUL_B)) begin
          state_nxt = mdru_pkg::ST_MUL;
        end else if (in_acc && is_write &&
                     (in_bus.reg_offset == mdru_pkg::ADDR_DIVD_LO)) begin
          state_nxt = mdru_pkg::ST_DIV;
        end
      end
      mdru_pkg::ST_MUL: begin
        if (mul_done) begin
          state_nxt = mdru_pkg::ST_IDLE;
        end
      end
      mdru_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = mdru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mdru_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_bus.ready = 1'b0;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    case (state_r)
      mdru_pkg::ST_IDLE: begin
        in_bus.ready = !out_valid_r || out_bus.ready;
        mul_start    = in_acc && is_write && (in_bus.reg_offset == mdru_pkg::ADDR_MUL_B);
        div_start    = in_acc && is_write &&
                       (in_bus.reg_offset == mdru_pkg::ADDR_DIVD_LO);
      end
      default: begin
        in_bus.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (in_bus.reg_offset)
      mdru_pkg::ADDR_PROD_LO: rd_byte = product[mdru_pkg::BYTE_W-1:0];
      mdru_pkg::ADDR_PROD_HI: rd_byte = product[mdru_pkg::WORD_W-1:mdru_pkg::BYTE_W];
      mdru_pkg::ADDR_REM_LO:  rd_byte = remainder[mdru_pkg::BYTE_W-1:0];
      mdru_pkg::ADDR_REM_HI:  rd_byte = remainder[mdru_pkg::WORD_W-1:mdru_pkg::BYTE_W];
      mdru_pkg::ADDR_QUOT_LO: rd_byte = quotient[mdru_pkg::BYTE_W-1:0];
      mdru_pkg::ADDR_QUOT_HI: rd_byte = quotient[mdru_pkg::WORD_W-1:mdru_pkg::BYTE_W];
      default:                rd_byte = '0;
    endcase
  end

  // output register frees the input side as soon as the word is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = is_write ? mdru_pkg::WRITE_RD : rd_byte;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.read_data = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mdru_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mdru_pkg::NUM_OPERANDS; i++) begin
        opnd_r[i] <= '0;
      end
    end else if (in_acc && is_write &&
                 (in_bus.reg_offset < mdru_pkg::ADDR_W'(mdru_pkg::NUM_OPERANDS))) begin
      opnd_r[in_bus.reg_offset] <= in_bus.write_data;
    end
  end

endmodule

// ===== rtl/mdru_mul.sv =====
// bit-serial 8x8 unsigned shift-and-add multiplier, one multiplier bit a cycle
// depends on mdru_pkg
module mdru_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mdru_pkg::mdru_mul_req_t       req,
  output logic                          done,
  output logic [mdru_pkg::WORD_W-1:0]   product
);

  logic                               busy_r, busy_nxt;
  logic [mdru_pkg::MUL_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [mdru_pkg::WORD_W-1:0]        product_r, product_nxt;
  logic [mdru_pkg::WORD_W-1:0]        mcand_r, mcand_nxt;
  logic [mdru_pkg::BYTE_W-1:0]        mplier_r, mplier_nxt;

  assign done    = busy_r && (cnt_r == mdru_pkg::MUL_LAST);
  assign product = product_r;

  always_comb begin
    busy_nxt    = busy_r;
    cnt_nxt     = cnt_r;
    product_nxt = product_r;
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    if (req.start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      product_nxt = '0;
      mcand_nxt   = {{(mdru_pkg::WORD_W-mdru_pkg::BYTE_W){1'b0}}, req.mcand};
      mplier_nxt  = req.mplier;
    end else if (busy_r) begin
      // add the shifted multiplicand where the current multiplier bit is set
      product_nxt = product_r + (mplier_r[0] ? mcand_r : '0);
      mcand_nxt   = {mcand_r[mdru_pkg::WORD_W-2:0], 1'b0};
      mplier_nxt  = {1'b0, mplier_r[mdru_pkg::BYTE_W-1:1]};
      cnt_nxt     = cnt_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      cnt_r     <= '0;
      product_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      cnt_r     <= cnt_nxt;
      product_r <= product_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

endmodule

// ===== rtl/mdru_div.sv =====
// restoring 16/16 unsigned divider, one quotient bit a cycle
// depends on mdru_pkg
module mdru_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mdru_pkg::mdru_div_req_t       req,
  output logic                          done,
  output logic [mdru_pkg::WORD_W-1:0]   quotient,
  output logic [mdru_pkg::WORD_W-1:0]   remainder
);

  logic                               busy_r, busy_nxt;
  logic                               zero_r, zero_nxt;
  logic [mdru_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [mdru_pkg::WORD_W-1:0]        quot_r, quot_nxt;
  logic [mdru_pkg::WORD_W-1:0]        rem_r, rem_nxt;
  logic [mdru_pkg::WORD_W-1:0]        divisor_r, divisor_nxt;
  logic [mdru_pkg::WORD_W:0]          shifted;
  logic [mdru_pkg::WORD_W+1:0]        diff;
  logic                               fits;

  assign done      = busy_r && (cnt_r == mdru_pkg::DIV_LAST);
  assign quotient  = quot_r;
  assign remainder = rem_r;

  // partial remainder with the next dividend bit brought down
  assign shifted = {rem_r, quot_r[mdru_pkg::WORD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_r};
  assign fits    = !diff[mdru_pkg::WORD_W+1];

  always_comb begin
    busy_nxt    = busy_r;
    zero_nxt    = zero_r;
    cnt_nxt     = cnt_r;
    quot_nxt    = quot_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    if (req.start) begin
      busy_nxt    = 1'b1;
      zero_nxt    = (req.divisor == '0);
      cnt_nxt     = '0;
      quot_nxt    = req.dividend;
      rem_nxt     = '0;
      divisor_nxt = req.divisor;
    end else if (busy_r) begin
      quot_nxt = {quot_r[mdru_pkg::WORD_W-2:0], fits};
      rem_nxt  = fits ? diff[mdru_pkg::WORD_W-1:0] : shifted[mdru_pkg::WORD_W-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
        if (zero_r) begin
          quot_nxt = mdru_pkg::ZDIV_QUOT;
          rem_nxt  = mdru_pkg::ZDIV_REM;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      quot_r <= '0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zero_r    <= zero_nxt;
    divisor_r <= divisor_nxt;
  end

endmodule

// ===== rtl/mdru_checker.sv =====
// port-level checks of the multiply/divide register unit, bound to the top level
// depends on mdru_pkg and the assertion macro header
`include "multiply_divide_register_unit_defines.svh"

module mdru_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_func,
  input logic [mdru_pkg::ADDR_W-1:0]    in_reg_offset,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mdru_pkg::BYTE_W-1:0]    out_read_data
);

  logic in_acc;
  logic wr_acc;

  assign in_acc = in_valid && in_ready;
  assign wr_acc = in_acc && (in_func == mdru_pkg::FUNC_WRITE);

  `MDRU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_read_data), "stalled word changed")
  `MDRU_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "word shown after reset")
  `MDRU_ASSERT(a_write_zero, wr_acc |=> out_valid && (out_read_data == mdru_pkg::WRITE_RD), "write gave nonzero data")
  `MDRU_ASSERT(a_mul_busy, wr_acc && (in_reg_offset == mdru_pkg::ADDR_MUL_B) |-> ##8 !in_ready, "word taken during multiply")
  `MDRU_ASSERT(a_div_busy, wr_acc && (in_reg_offset == mdru_pkg::ADDR_DIVD_LO) |-> ##16 !in_ready, "word taken during divide")

endmodule

bind multiply_divide_register_unit mdru_checker u_mdru_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .in_func       (in_bus.func),
  .in_reg_offset (in_bus.reg_offset),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_read_data (out_bus.read_data)
);

// ===== sim/tb_multiply_divide_register_unit.sv =====
`timescale 1ns / 1ps
// testbench for the multiply/divide register unit: directed and random bus accesses
// checked against a shadow of the operand, product, quotient and remainder registers
// depends on mdru_pkg, mdru_in_if, mdru_out_if and multiply_divide_register_unit
module tb_multiply_divide_register_unit;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam logic [mdru_pkg::ADDR_W-1:0] ADDR_SPARE_6 = 3'd6;
  localparam logic [mdru_pkg::ADDR_W-1:0] ADDR_SPARE_7 = 3'd7;

  typedef struct {
    logic                        func;
    logic [mdru_pkg::ADDR_W-1:0] reg_offset;
    logic [mdru_pkg::BYTE_W-1:0] write_data;
  } bus_access_t;

  logic clk = 1'b0;
  logic rst_n;

  mdru_in_if  in_ch ();
  mdru_out_if out_ch ();

  multiply_divide_register_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  bus_access_t                 access_q[$];
  logic [mdru_pkg::BYTE_W-1:0] exp_read_data[$];

  // shadow of the block's registers
  logic [mdru_pkg::BYTE_W-1:0] sh_opnd [mdru_pkg::NUM_OPERANDS] = '{default: '0};
  logic [mdru_pkg::WORD_W-1:0] sh_prod = '0;
  logic [mdru_pkg::WORD_W-1:0] sh_quot = '0;
  logic [mdru_pkg::WORD_W-1:0] sh_rem  = '0;

  int   send_idle_pct;
  int   stall_pct;
  logic out_hold;
  logic hold_go = 1'b0;
  int   n_queued;
  int   n_results = 0;
  int   n_fail = 0;
  int   idle_cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // applies one access to the shadow registers and gives the byte it reads back
  function automatic logic [mdru_pkg::BYTE_W-1:0] bus_access_byte(
      logic f, logic [mdru_pkg::ADDR_W-1:0] a, logic [mdru_pkg::BYTE_W-1:0] d);
    logic [mdru_pkg::WORD_W-1:0] dividend;
    logic [mdru_pkg::WORD_W-1:0] divisor;
    if (f == mdru_pkg::FUNC_WRITE) begin
      if (a < mdru_pkg::NUM_OPERANDS) sh_opnd[a] = d;
      if (a == mdru_pkg::ADDR_MUL_B) begin
        sh_prod = {8'h00, sh_opnd[mdru_pkg::ADDR_MUL_A]} * {8'h00, sh_opnd[mdru_pkg::ADDR_MUL_B]};
      end else if (a == mdru_pkg::ADDR_DIVD_LO) begin
        dividend = {sh_opnd[mdru_pkg::ADDR_DIVD_HI], sh_opnd[mdru_pkg::ADDR_DIVD_LO]};
        divisor  = {sh_opnd[mdru_pkg::ADDR_DIVR_HI], sh_opnd[mdru_pkg::ADDR_DIVR_LO]};
        if (divisor == '0) begin
          sh_quot = mdru_pkg::ZDIV_QUOT;
          sh_rem  = mdru_pkg::ZDIV_REM;
        end else begin
          sh_quot = dividend / divisor;
          sh_rem  = dividend % divisor;
        end
      end
      return mdru_pkg::WRITE_RD;
    end
    case (a)
      mdru_pkg::ADDR_PROD_LO: return sh_prod[7:0];
      mdru_pkg::ADDR_PROD_HI: return sh_prod[15:8];
      mdru_pkg::ADDR_REM_LO:  return sh_rem[7:0];
      mdru_pkg::ADDR_REM_HI:  return sh_rem[15:8];
      mdru_pkg::ADDR_QUOT_LO: return sh_quot[7:0];
      mdru_pkg::ADDR_QUOT_HI: return sh_quot[15:8];
      default:                return 8'h00;
    endcase
  endfunction

  // driver: prediction is taken at the edge the word is accepted
  always @(posedge clk) begin
    bus_access_t nxt;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.func       <= mdru_pkg::FUNC_READ;
      in_ch.reg_offset <= mdru_pkg::ADDR_PROD_LO;
      in_ch.write_data <= 8'h00;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        exp_read_data.push_back(bus_access_byte(in_ch.func, in_ch.reg_offset,
                                                in_ch.write_data));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = access_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.func       <= nxt.func;
          in_ch.reg_offset <= nxt.reg_offset;
          in_ch.write_data <= nxt.write_data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [mdru_pkg::BYTE_W-1:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (exp_read_data.size() == 0) begin
          $error("read_data: no word expected, actual %02h", out_ch.read_data);
          n_fail++;
        end else begin
          want = exp_read_data.pop_front();
          if (out_ch.read_data !== want) begin
            $error("read_data: expected %02h, actual %02h", want, out_ch.read_data);
            n_fail++;
          end
        end
      end
      out_ch.ready <= !out_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold, counted here while the sender keeps offering words
  initial begin
    out_hold = 1'b0;
    wait (hold_go);
    out_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    out_hold = 1'b0;
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_access(logic f, logic [mdru_pkg::ADDR_W-1:0] a,
                             logic [mdru_pkg::BYTE_W-1:0] d);
    bus_access_t acc;
    acc.func       = f;
    acc.reg_offset = a;
    acc.write_data = d;
    access_q.push_back(acc);
    n_queued++;
  endtask

  function automatic logic [mdru_pkg::BYTE_W-1:0] edgy_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return mdru_pkg::BYTE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic read_back(logic [mdru_pkg::ADDR_W-1:0] lo, logic [mdru_pkg::ADDR_W-1:0] hi);
    if ($urandom_range(1) == 0) begin
      push_access(mdru_pkg::FUNC_READ, lo, mdru_pkg::BYTE_W'($urandom));
      push_access(mdru_pkg::FUNC_READ, hi, mdru_pkg::BYTE_W'($urandom));
    end else begin
      push_access(mdru_pkg::FUNC_READ, hi, mdru_pkg::BYTE_W'($urandom));
      push_access(mdru_pkg::FUNC_READ, lo, mdru_pkg::BYTE_W'($urandom));
    end
  endtask

  // mostly complete multiply and divide sequences, with some broken ones and noise
  task automatic add_random(int count);
    int stop_at;
    int pick;
    logic [mdru_pkg::BYTE_W-1:0] dvr_hi;
    logic [mdru_pkg::BYTE_W-1:0] dvr_lo;
    stop_at = n_queued + count;
    while (n_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        if ($urandom_range(3) != 0) begin
          push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_MUL_A, edgy_byte());
        end
        push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_MUL_B, edgy_byte());
        read_back(mdru_pkg::ADDR_PROD_LO, mdru_pkg::ADDR_PROD_HI);
      end else if (pick < 70) begin
        case ($urandom_range(7))
          0: begin
            dvr_hi = 8'h00;
            dvr_lo = 8'h00;
          end
          1, 2, 3: begin
            dvr_hi = 8'h00;
            dvr_lo = edgy_byte();
          end
          default: begin
            dvr_hi = edgy_byte();
            dvr_lo = edgy_byte();
          end
        endcase
        if ($urandom_range(3) != 0) begin
          push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_DIVR_HI, dvr_hi);
        end
        if ($urandom_range(3) != 0) begin
          push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_DIVR_LO, dvr_lo);
        end
        if ($urandom_range(3) != 0) begin
          push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_DIVD_HI, edgy_byte());
        end
        if ($urandom_range(7) != 0) begin
          push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_DIVD_LO, edgy_byte());
        end
        read_back(mdru_pkg::ADDR_QUOT_LO, mdru_pkg::ADDR_QUOT_HI);
        read_back(mdru_pkg::ADDR_REM_LO, mdru_pkg::ADDR_REM_HI);
      end else begin
        repeat ($urandom_range(3, 1)) begin
          push_access(1'($urandom), mdru_pkg::ADDR_W'($urandom), mdru_pkg::BYTE_W'($urandom));
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (n_results < n_queued) @(negedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    n_queued      = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset values, widest product, zero and widest divisor, spare addresses
    push_access(mdru_pkg::FUNC_READ,  mdru_pkg::ADDR_PROD_LO, 8'hff);
    push_access(mdru_pkg::FUNC_READ,  mdru_pkg::ADDR_QUOT_HI, 8'h00);
    push_access(mdru_pkg::FUNC_READ,  ADDR_SPARE_7,           8'hff);
    push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_MUL_A,   8'hff);
    push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_MUL_B,   8'hff);
    push_access(mdru_pkg::FUNC_READ,  mdru_pkg::ADDR_PROD_LO, 8'h00);
    push_access(mdru_pkg::FUNC_READ,  mdru_pkg::ADDR_PROD_HI, 8'h00);
    push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_DIVR_HI, 8'h00);
    push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_DIVR_LO, 8'h00);
    push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_DIVD_HI, 8'hff);
    push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_DIVD_LO, 8'hff);
    push_access(mdru_pkg::FUNC_READ,  mdru_pkg::ADDR_QUOT_LO, 8'h00);
    push_access(mdru_pkg::FUNC_READ,  mdru_pkg::ADDR_QUOT_HI, 8'hff);
    push_access(mdru_pkg::FUNC_READ,  mdru_pkg::ADDR_REM_LO,  8'h00);
    push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_DIVR_HI, 8'hff);
    push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_DIVR_LO, 8'hff);
    push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_DIVD_LO, 8'h00);
    push_access(mdru_pkg::FUNC_READ,  mdru_pkg::ADDR_REM_HI,  8'h00);
    push_access(mdru_pkg::FUNC_READ,  mdru_pkg::ADDR_QUOT_LO, 8'hff);
    push_access(mdru_pkg::FUNC_WRITE, ADDR_SPARE_6,           8'hff);
    push_access(mdru_pkg::FUNC_WRITE, ADDR_SPARE_7,           8'hff);
    push_access(mdru_pkg::FUNC_READ,  ADDR_SPARE_6,           8'hff);
    push_access(mdru_pkg::FUNC_WRITE, mdru_pkg::ADDR_MUL_B,   8'h00);
    push_access(mdru_pkg::FUNC_READ,  mdru_pkg::ADDR_PROD_HI, 8'hff);
    push_access(mdru_pkg::FUNC_READ,  mdru_pkg::ADDR_REM_LO,  8'h00);
    add_random(250);
    wait_drained();

    send_idle_pct = 74;
    add_random(260);
    wait_drained();

    send_idle_pct = 0;
    stall_pct     = 74;
    add_random(260);
    wait_drained();

    send_idle_pct = 38;
    stall_pct     = 38;
    add_random(260);
    wait_drained();

    // receiver holds off while words keep coming, so the input backs up
    send_idle_pct = 0;
    stall_pct     = 0;
    add_random(40);
    hold_go = 1'b1;
    wait_drained();

    add_random(230);
    wait_drained();

    repeat (20) @(negedge clk);
    if (n_fail == 0 && exp_read_data.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
